// ===== hdl/pmg_pkg.sv =====
// shared types, widths and codes for the point-mass gravity accumulator
// no dependencies; imported by every module of the block
package pmg_pkg;

	// default depth of the attractor table
	localparam int DEF_MAX_ATTRACTORS = 16;

	// datapath widths
	localparam int MAG_W  = 32;   // |attractor - body| per axis
	localparam int MUL_W  = 33;   // shared multiplier operand
	localparam int PROD_W = 66;   // shared multiplier product
	localparam int DIST_W = 66;   // squared distance
	localparam int ROOT_W = 33;   // floor square root of squared distance
	localparam int GM_W   = 64;   // gravity constant times mass
	localparam int DEN_W  = 99;   // squared distance times root
	localparam int NUM_W  = 97;   // gm times axis magnitude, before the Q16 shift
	localparam int QUO_W  = 59;   // term magnitude, clipped to the term limit

	localparam logic [QUO_W-1:0] TERM_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

	// input word command codes
	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// configuration register indexes
	typedef enum logic {
		CFG_GRAVITY = 1'b0,
		CFG_COUNT   = 1'b1
	} cfg_idx_t;

	// one attractor table entry
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] mass;
	} attractor_t;

	// multiplier micro-ops, in issue order
	typedef enum logic [2:0] {
		OP_SQ0,
		OP_SQ1,
		OP_SQ2,
		OP_GM,
		OP_DEN_LO,
		OP_DEN_HI,
		OP_NUM_LO,
		OP_NUM_HI
	} op_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_NEXT,
		S_READ,
		S_DIFF,
		S_MUL,
		S_SQRT,
		S_DIVGO,
		S_DIV,
		S_OUT
	} state_t;

endpackage

// ===== hdl/pmg_table.sv =====
// attractor table: one write port, one registered read port
// depends on pmg_pkg for the entry type
module pmg_table #(
	parameter int MAX_ATTRACTORS = pmg_pkg::DEF_MAX_ATTRACTORS,
	localparam int IDX_W = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_W-1:0]     waddr,
	input  pmg_pkg::attractor_t  wdata,
	input  logic [IDX_W-1:0]     raddr,
	output pmg_pkg::attractor_t  rdata
);
	import pmg_pkg::*;

	attractor_t mem [MAX_ATTRACTORS];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/pmg_mul.sv =====
// shared unsigned multiplier with a registered product
// depends on pmg_pkg for operand widths
module pmg_mul (
	input  logic                       clk,
	input  logic [pmg_pkg::MUL_W-1:0]  a,
	input  logic [pmg_pkg::MUL_W-1:0]  b,
	output logic [pmg_pkg::PROD_W-1:0] prod
);
	import pmg_pkg::*;

	// one product per cycle
	always_ff @(posedge clk) begin
		prod <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// ===== hdl/pmg_sqrt.sv =====
// digit-by-digit integer square root, two radicand bits per cycle
// depends on pmg_pkg for widths
module pmg_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pmg_pkg::DIST_W-1:0] radicand,
	output logic                       done,
	output logic [pmg_pkg::ROOT_W-1:0] root
);
	import pmg_pkg::*;

	localparam int REM_W = ROOT_W + 1;

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [DIST_W-1:0] rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic              ge;

	// one trial subtract per step
	always_comb begin
		rem_sh = {rem_q, rad_q[DIST_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_sh >= trial;
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(ROOT_W - 1);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 6'd1;
			busy_q <= (cnt_q != '0);
			done_q <= (cnt_q == '0);
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[DIST_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/pmg_div.sv =====
// restoring divider for one acceleration term, one quotient bit per cycle
// depends on pmg_pkg for widths and the term limit
module pmg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pmg_pkg::NUM_W-1:0] num,
	input  logic [pmg_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [pmg_pkg::QUO_W-1:0] quo,
	output logic                      sat
);
	import pmg_pkg::*;

	// dividend is num shifted up by 16; bits at and above QUO_W form the first remainder
	localparam int TOP_LSB = QUO_W - 16;
	localparam int TOP_W   = NUM_W - TOP_LSB;

	logic             busy_q;
	logic             done_q;
	logic             presat_q;
	logic [5:0]       cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] low_q;
	logic [QUO_W-1:0] q_q;

	logic [TOP_W-1:0] top;
	logic             big;
	logic [DEN_W:0]   r_sh;
	logic [DEN_W:0]   r_sub;
	logic             ge;
	logic             over;

	// quotient too large before any step, and the per-step trial subtract
	always_comb begin
		top   = num[NUM_W-1:TOP_LSB];
		big   = DEN_W'(top) >= den;
		r_sh  = {rem_q, low_q[QUO_W-1]};
		r_sub = r_sh - {1'b0, den};
		ge    = r_sh >= {1'b0, den};
		over  = q_q > TERM_LIMIT;
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			presat_q <= 1'b0;
			cnt_q    <= '0;
		end else if (start) begin
			busy_q   <= !big;
			done_q   <= big;
			presat_q <= big;
			cnt_q    <= 6'(QUO_W - 1);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 6'd1;
			busy_q <= (cnt_q != '0);
			done_q <= (cnt_q == '0);
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder, dividend bits and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(top);
			low_q <= {num[TOP_LSB-1:0], 16'd0};
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			q_q   <= {q_q[QUO_W-2:0], ge};
		end
	end

	// clip to the term limit
	assign done = done_q;
	assign sat  = presat_q | over;
	assign quo  = (presat_q | over) ? TERM_LIMIT : q_q;

endmodule

// ===== hdl/point_mass_gravity_accumulator_core.sv =====
// point-mass gravity accumulator: a load gives no word; the time a query takes for n
// attractors is set by the shared divider (up to 59 steps, one quotient bit a cycle,
// three terms per attractor) and the 33-step root unit.
// one item at a time; busy is high while a query runs, done strobes the result word.
// reset clears the sequencer and config (G = 1.0, count = 0); the table is not cleared.
module point_mass_gravity_accumulator_core #(
	parameter int MAX_ATTRACTORS = pmg_pkg::DEF_MAX_ATTRACTORS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [3:0]         slot,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [31:0]        mass,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] accel_x,
	output logic signed [31:0] accel_y,
	output logic signed [31:0] accel_z,
	output logic               saturated
);
	import pmg_pkg::*;

	localparam int IDX_W = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
	localparam int CNT_W = $clog2(MAX_ATTRACTORS + 1);
	localparam int SUM_W = 60 + CNT_W;
	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_ATTRACTORS);

	// control registers
	state_t            state_q, state_d;
	logic [31:0]       gconst_q;
	logic [4:0]        count_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  j_q;
	op_t               op_q;
	logic              ph_q;
	logic [1:0]        ax_q;
	logic              flag_q;
	logic              done_q;

	// datapath registers
	logic signed [31:0]       px_q, py_q, pz_q;
	logic [MAG_W-1:0]         mag_q [3];
	logic [2:0]               neg_q;
	logic [DIST_W-1:0]        dist_q;
	logic [GM_W-1:0]          gm_q;
	logic [DEN_W-1:0]         den_q;
	logic [NUM_W-1:0]         num_q;
	logic signed [SUM_W-1:0]  sum_q [3];
	logic [31:0]              acc_q [3];
	logic                     sat_q;

	// combinational
	logic               accept;
	logic               load_we;
	logic               sqrt_start;
	logic               div_start;
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [PROD_W-1:0]  prod;
	logic [MAG_W-1:0]   mag_sel;
	logic               neg_sel;
	attractor_t         wr_entry;
	attractor_t         rd_entry;
	logic               sqrt_done;
	logic [ROOT_W-1:0]  root;
	logic               div_done;
	logic [QUO_W-1:0]   quo;
	logic               div_sat;
	logic [32:0]        dif [3];
	logic [31:0]        clip [3];
	logic [2:0]         clip_hit;
	logic [SUM_W-1:0]   tmag;

	assign accept  = start && (state_q == S_IDLE);
	assign load_we = accept && (command == CMD_LOAD) &&
		({28'd0, slot} < 32'(MAX_ATTRACTORS));
	assign wr_entry = '{x: pos_x, y: pos_y, z: pos_z, mass: mass};

	pmg_table #(.MAX_ATTRACTORS(MAX_ATTRACTORS)) u_table (
		.clk   (clk),
		.we    (load_we),
		.waddr (IDX_W'(slot)),
		.wdata (wr_entry),
		.raddr (IDX_W'(j_q)),
		.rdata (rd_entry)
	);

	pmg_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pmg_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (dist_q),
		.done     (sqrt_done),
		.root     (root)
	);

	pmg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo),
		.sat    (div_sat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (command == CMD_QUERY)) state_d = S_NEXT;
			end
			S_NEXT:  state_d = (j_q == n_q) ? S_OUT : S_READ;
			S_READ:  state_d = S_DIFF;
			S_DIFF:  state_d = S_MUL;
			S_MUL: begin
				if (ph_q) begin
					if (op_q == OP_GM) begin
						state_d = (dist_q == '0) ? S_NEXT : S_SQRT;
					end else if (op_q == OP_NUM_HI) begin
						state_d = S_DIVGO;
					end
				end
			end
			S_SQRT: begin
				if (sqrt_done) state_d = S_MUL;
			end
			S_DIVGO: state_d = S_DIV;
			S_DIV: begin
				if (div_done) state_d = (ax_q == 2'd2) ? S_NEXT : S_MUL;
			end
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs and multiplier operand select
	always_comb begin
		busy       = (state_q != S_IDLE);
		sqrt_start = (state_q == S_MUL) && ph_q && (op_q == OP_GM) && (dist_q != '0);
		div_start  = (state_q == S_DIVGO);
		unique case (ax_q)
			2'd0:    begin mag_sel = mag_q[0]; neg_sel = neg_q[0]; end
			2'd1:    begin mag_sel = mag_q[1]; neg_sel = neg_q[1]; end
			default: begin mag_sel = mag_q[2]; neg_sel = neg_q[2]; end
		endcase
		unique case (op_q)
			OP_SQ0:    begin mul_a = {1'b0, mag_q[0]};      mul_b = {1'b0, mag_q[0]}; end
			OP_SQ1:    begin mul_a = {1'b0, mag_q[1]};      mul_b = {1'b0, mag_q[1]}; end
			OP_SQ2:    begin mul_a = {1'b0, mag_q[2]};      mul_b = {1'b0, mag_q[2]}; end
			OP_GM:     begin mul_a = {1'b0, gconst_q};      mul_b = {1'b0, rd_entry.mass}; end
			OP_DEN_LO: begin mul_a = dist_q[32:0];          mul_b = root; end
			OP_DEN_HI: begin mul_a = dist_q[65:33];         mul_b = root; end
			OP_NUM_LO: begin mul_a = {1'b0, gm_q[31:0]};    mul_b = {1'b0, mag_sel}; end
			OP_NUM_HI: begin mul_a = {1'b0, gm_q[63:32]};   mul_b = {1'b0, mag_sel}; end
		endcase
	end

	// axis differences and output clipping
	always_comb begin
		dif[0] = {rd_entry.x[31], rd_entry.x} - {px_q[31], px_q};
		dif[1] = {rd_entry.y[31], rd_entry.y} - {py_q[31], py_q};
		dif[2] = {rd_entry.z[31], rd_entry.z} - {pz_q[31], pz_q};
		tmag   = SUM_W'(quo);
		for (int k = 0; k < 3; k++) begin
			clip_hit[k] = !((&sum_q[k][SUM_W-1:31]) || !(|sum_q[k][SUM_W-1:31]));
			if (clip_hit[k]) begin
				clip[k] = sum_q[k][SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				clip[k] = sum_q[k][31:0];
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			gconst_q <= 32'h0001_0000;
			count_q  <= '0;
			n_q      <= '0;
			j_q      <= '0;
			op_q     <= OP_SQ0;
			ph_q     <= 1'b0;
			ax_q     <= '0;
			flag_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_OUT);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_GRAVITY: gconst_q <= cfg_data;
					CFG_COUNT:   count_q  <= cfg_data[4:0];
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (command == CMD_QUERY)) begin
						j_q    <= '0;
						flag_q <= 1'b0;
						n_q    <= (32'(count_q) > 32'(MAX_ATTRACTORS)) ? MAX_N
							: CNT_W'(count_q);
					end
				end
				S_DIFF: begin
					op_q <= OP_SQ0;
					ph_q <= 1'b0;
				end
				S_MUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						unique case (op_q)
							OP_SQ0:    op_q <= OP_SQ1;
							OP_SQ1:    op_q <= OP_SQ2;
							OP_SQ2:    op_q <= OP_GM;
							OP_GM: begin
								op_q <= OP_DEN_LO;
								if (dist_q == '0) j_q <= j_q + 1'b1;
							end
							OP_DEN_LO: op_q <= OP_DEN_HI;
							OP_DEN_HI: begin
								op_q <= OP_NUM_LO;
								ax_q <= '0;
							end
							OP_NUM_LO: op_q <= OP_NUM_HI;
							OP_NUM_HI: op_q <= OP_NUM_LO;
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						flag_q <= flag_q | div_sat;
						if (ax_q == 2'd2) begin
							j_q <= j_q + 1'b1;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept && (command == CMD_QUERY)) begin
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
			for (int k = 0; k < 3; k++) sum_q[k] <= '0;
		end
		if (state_q == S_DIFF) begin
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= dif[k][32];
				mag_q[k] <= dif[k][32] ? MAG_W'(-dif[k]) : dif[k][31:0];
			end
		end
		if ((state_q == S_MUL) && ph_q) begin
			unique case (op_q)
				OP_SQ0:    dist_q <= prod;
				OP_SQ1:    dist_q <= dist_q + prod;
				OP_SQ2:    dist_q <= dist_q + prod;
				OP_GM:     gm_q   <= prod[GM_W-1:0];
				OP_DEN_LO: den_q  <= DEN_W'(prod);
				OP_DEN_HI: den_q  <= den_q + {prod, 33'd0};
				OP_NUM_LO: num_q  <= NUM_W'(prod);
				OP_NUM_HI: num_q  <= num_q + {prod[64:0], 32'd0};
			endcase
		end
		if ((state_q == S_DIV) && div_done) begin
			unique case (ax_q)
				2'd0:    sum_q[0] <= neg_sel ? sum_q[0] - tmag : sum_q[0] + tmag;
				2'd1:    sum_q[1] <= neg_sel ? sum_q[1] - tmag : sum_q[1] + tmag;
				default: sum_q[2] <= neg_sel ? sum_q[2] - tmag : sum_q[2] + tmag;
			endcase
		end
		if (state_q == S_OUT) begin
			for (int k = 0; k < 3; k++) acc_q[k] <= clip[k];
			sat_q <= flag_q | (|clip_hit);
		end
	end

	// result word
	assign done      = done_q;
	assign accel_x   = acc_q[0];
	assign accel_y   = acc_q[1];
	assign accel_z   = acc_q[2];
	assign saturated = sat_q;

endmodule
